// File: hdl/dpcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER primitive content checker package
// Shared types, tag codes and status codes.
// ----------------------------------------------------------------------------
package dpcc_pkg;

	localparam logic [7:0] TAG_BOOLEAN   = 8'd1;
	localparam logic [7:0] TAG_INTEGER   = 8'd2;
	localparam logic [7:0] TAG_BITSTR    = 8'd3;
	localparam logic [7:0] TAG_OCTSTR    = 8'd4;
	localparam logic [7:0] TAG_NULL      = 8'd5;
	localparam logic [7:0] TAG_OID       = 8'd6;
	localparam logic [7:0] TAG_REAL      = 8'd9;
	localparam logic [7:0] TAG_ENUM      = 8'd10;
	localparam logic [7:0] TAG_UTF8      = 8'd12;
	localparam logic [7:0] TAG_RELOID    = 8'd13;
	localparam logic [7:0] TAG_NUMERIC   = 8'd18;
	localparam logic [7:0] TAG_PRINTABLE = 8'd19;
	localparam logic [7:0] TAG_IA5       = 8'd22;
	localparam logic [7:0] TAG_UTCTIME   = 8'd23;
	localparam logic [7:0] TAG_GENTIME   = 8'd24;
	localparam logic [7:0] TAG_VISIBLE   = 8'd26;
	localparam logic [7:0] TAG_UNIVERSAL = 8'd28;
	localparam logic [7:0] TAG_BMP       = 8'd30;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_INVALID     = 2'd1;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

	localparam logic [2:0] FR_NONE  = 3'd0;
	localparam logic [2:0] FR_DOT   = 3'd1;
	localparam logic [2:0] FR_NZ    = 3'd2;
	localparam logic [2:0] FR_ZERO  = 3'd3;
	localparam logic [2:0] FR_ZULU  = 3'd4;

	typedef struct packed {
		logic [7:0]  elem_tag;
		logic [4:0]  byte_count;
		logic [1:0]  group_phase;
		logic        invalid_seen;
		logic [7:0]  first_octet;
		logic [7:0]  prior_octet;
		logic [1:0]  utf8_pending;
		logic [31:0] code_point;
		logic [1:0]  utf8_min_class;
		logic        oid_continuing;
		logic [3:0]  tens_digit;
		logic [2:0]  fraction_phase;
		logic [1:0]  real_exponent_len;
		logic        mantissa_lead_zero;
	} elem_state_t;

	typedef struct packed {
		logic [7:0] tag_number;
		logic [7:0] data_byte;
		logic       last_byte;
		logic       empty_element;
	} item_t;

	function automatic logic is_dig(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

endpackage

// File: hdl/dpcc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER content checker step logic
// Combinational update of the element state for one item, plus the verdict.
// ----------------------------------------------------------------------------
module dpcc_step (
	input  dpcc_pkg::elem_state_t cur,
	input  dpcc_pkg::item_t       item,
	output dpcc_pkg::elem_state_t nxt,
	output logic                  done,
	output logic [1:0]            verdict
);

	dpcc_pkg::elem_state_t s;
	dpcc_pkg::elem_state_t t;
	logic [7:0]  b;
	logic [4:0]  n;
	logic [31:0] cp;
	logic [31:0] minv;
	logic [3:0]  fidx;
	logic [6:0]  tv;
	logic [6:0]  lo;
	logic [6:0]  hi;
	logic [1:0]  e;
	logic [2:0]  m;
	logic        ok;
	logic        time_on;
	logic [2:0]  yp;
	logic [7:0]  bmask;

	always_comb begin
		s = cur;
		if (cur.byte_count == 5'd0) begin
			s = '0;
			s.elem_tag = item.tag_number;
		end
		t = s;
		b = item.data_byte;
		n = s.byte_count;
		cp = '0;
		minv = '0;
		fidx = '0;
		tv = '0;
		lo = '0;
		hi = '0;
		e = s.real_exponent_len;
		m = 3'd1 + {1'b0, e};
		time_on = 1'b0;
		yp = '0;
		if (!item.empty_element) begin
			case (s.elem_tag)
				dpcc_pkg::TAG_BOOLEAN: begin
					if (n == 5'd0 && b != 8'h00 && b != 8'hFF) t.invalid_seen = 1'b1;
				end
				dpcc_pkg::TAG_INTEGER, dpcc_pkg::TAG_ENUM: begin
					if (n == 5'd0) t.first_octet = b;
					else if (n == 5'd1 && ((s.first_octet == 8'h00 && !b[7]) ||
						(s.first_octet == 8'hFF && b[7]))) t.invalid_seen = 1'b1;
				end
				dpcc_pkg::TAG_BITSTR: begin
					if (n == 5'd0) begin
						t.first_octet = b;
						if (b > 8'd7) t.invalid_seen = 1'b1;
					end
				end
				dpcc_pkg::TAG_OID, dpcc_pkg::TAG_RELOID: begin
					if (!s.oid_continuing && b == 8'h80) t.invalid_seen = 1'b1;
					t.oid_continuing = b[7];
				end
				dpcc_pkg::TAG_REAL: begin
					if (n == 5'd0) begin
						t.first_octet = b;
						if (!b[7]) begin
							if (!b[6] || b > 8'h43) t.invalid_seen = 1'b1;
						end else if (b[5:4] != 2'b00 || b[3:2] != 2'b00 || b[1:0] == 2'b11) begin
							t.invalid_seen = 1'b1;
						end else begin
							t.real_exponent_len = b[1:0] + 2'd1;
						end
					end else if (e == 2'd0) begin
						t.invalid_seen = 1'b1;
					end else begin
						if (n == 5'd2 && e >= 2'd2 && ((s.prior_octet == 8'h00 && !b[7]) ||
							(s.prior_octet == 8'hFF && b[7]))) t.invalid_seen = 1'b1;
						if (n == {2'b00, m}) t.mantissa_lead_zero = (b == 8'h00);
						if (n == {2'b00, m} + 5'd1 && s.mantissa_lead_zero)
							t.invalid_seen = 1'b1;
					end
				end
				dpcc_pkg::TAG_UTF8: begin
					if (s.utf8_pending == 2'd0) begin
						if (b[7]) begin
							if (b[7:5] == 3'b110) begin
								t.utf8_pending = 2'd1;
								t.code_point = {27'd0, b[4:0]};
								t.utf8_min_class = 2'd1;
							end else if (b[7:4] == 4'b1110) begin
								t.utf8_pending = 2'd2;
								t.code_point = {28'd0, b[3:0]};
								t.utf8_min_class = 2'd2;
							end else if (b[7:3] == 5'b11110) begin
								t.utf8_pending = 2'd3;
								t.code_point = {29'd0, b[2:0]};
								t.utf8_min_class = 2'd3;
							end else begin
								t.invalid_seen = 1'b1;
							end
						end
					end else if (b[7:6] != 2'b10) begin
						t.invalid_seen = 1'b1;
						t.utf8_pending = 2'd0;
					end else begin
						cp = {11'd0, s.code_point[14:0], b[5:0]};
						t.code_point = cp;
						t.utf8_pending = s.utf8_pending - 2'd1;
						if (s.utf8_pending == 2'd1) begin
							case (s.utf8_min_class)
								2'd1:    minv = 32'h80;
								2'd2:    minv = 32'h800;
								default: minv = 32'h10000;
							endcase
							if (cp < minv || cp > 32'h10FFFF ||
								(cp >= 32'hD800 && cp <= 32'hDFFF)) t.invalid_seen = 1'b1;
						end
					end
				end
				dpcc_pkg::TAG_NUMERIC: begin
					if (!dpcc_pkg::is_dig(b) && b != 8'h20) t.invalid_seen = 1'b1;
				end
				dpcc_pkg::TAG_PRINTABLE: begin
					if (!((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
						dpcc_pkg::is_dig(b) || b == 8'h20 || b == 8'h27 || b == 8'h28 ||
						b == 8'h29 || b == 8'h2B || b == 8'h2C || b == 8'h2D ||
						b == 8'h2E || b == 8'h2F || b == 8'h3A || b == 8'h3D ||
						b == 8'h3F)) t.invalid_seen = 1'b1;
				end
				dpcc_pkg::TAG_IA5: begin
					if (b > 8'h7F) t.invalid_seen = 1'b1;
				end
				dpcc_pkg::TAG_VISIBLE: begin
					if (b < 8'h20 || b > 8'h7E) t.invalid_seen = 1'b1;
				end
				dpcc_pkg::TAG_UTCTIME: begin
					if (n < 5'd12) begin
						time_on = 1'b1;
						yp = 3'd1;
					end else if (n > 5'd12 || b != 8'h5A) t.invalid_seen = 1'b1;
				end
				dpcc_pkg::TAG_GENTIME: begin
					if (n < 5'd14) begin
						time_on = 1'b1;
						yp = 3'd2;
					end else begin
						case (s.fraction_phase)
							dpcc_pkg::FR_NONE: begin
								if (b == 8'h2E) t.fraction_phase = dpcc_pkg::FR_DOT;
								else if (b == 8'h5A) t.fraction_phase = dpcc_pkg::FR_ZULU;
								else t.invalid_seen = 1'b1;
							end
							dpcc_pkg::FR_DOT, dpcc_pkg::FR_NZ, dpcc_pkg::FR_ZERO: begin
								if (dpcc_pkg::is_dig(b))
									t.fraction_phase = (b == 8'h30) ? dpcc_pkg::FR_ZERO
										: dpcc_pkg::FR_NZ;
								else if (b == 8'h5A && s.fraction_phase == dpcc_pkg::FR_NZ)
									t.fraction_phase = dpcc_pkg::FR_ZULU;
								else t.invalid_seen = 1'b1;
							end
							default: t.invalid_seen = 1'b1;
						endcase
					end
				end
				dpcc_pkg::TAG_UNIVERSAL: begin
					cp = {s.code_point[23:0], b};
					t.code_point = cp;
					t.group_phase = s.group_phase + 2'd1;
					if (s.group_phase == 2'd3 && (cp > 32'h10FFFF ||
						(cp >= 32'hD800 && cp <= 32'hDFFF))) t.invalid_seen = 1'b1;
				end
				dpcc_pkg::TAG_BMP: begin
					cp = {16'd0, s.code_point[7:0], b};
					t.code_point = cp;
					t.group_phase = {1'b0, ~s.group_phase[0]};
					if (s.group_phase[0] && cp >= 32'hD800 && cp <= 32'hDFFF)
						t.invalid_seen = 1'b1;
				end
				default: ;
			endcase
			// Calendar digits: even positions are tens, odd positions close a field.
			if (time_on) begin
				if (!dpcc_pkg::is_dig(b)) begin
					t.invalid_seen = 1'b1;
				end else if (!n[0]) begin
					t.tens_digit = b[3:0];
				end else if ({1'b0, n[4:1]} >= {2'b00, yp}) begin
					fidx = n[4:1] - {1'b0, yp};
					tv = {s.tens_digit, 3'b000} + {2'b00, s.tens_digit, 1'b0} + {3'd0, b[3:0]};
					case (fidx)
						4'd0:    begin lo = 7'd1; hi = 7'd12; end
						4'd1:    begin lo = 7'd1; hi = 7'd31; end
						4'd2:    begin lo = 7'd0; hi = 7'd23; end
						default: begin lo = 7'd0; hi = 7'd59; end
					endcase
					if (fidx <= 4'd4 && (tv < lo || tv > hi)) t.invalid_seen = 1'b1;
				end
			end
			t.prior_octet = b;
			if (s.byte_count != 5'd31) t.byte_count = s.byte_count + 5'd1;
		end

		done = item.empty_element || item.last_byte;
		bmask = (8'd1 << t.first_octet[2:0]) - 8'd1;
		ok = 1'b0;
		verdict = dpcc_pkg::ST_OK;
		case (t.elem_tag)
			dpcc_pkg::TAG_BOOLEAN: ok = (t.byte_count == 5'd1);
			dpcc_pkg::TAG_INTEGER, dpcc_pkg::TAG_ENUM: ok = (t.byte_count != 5'd0);
			dpcc_pkg::TAG_BITSTR: begin
				if (t.byte_count == 5'd0) ok = 1'b0;
				else if (t.byte_count == 5'd1) ok = (t.first_octet == 8'd0);
				else ok = ((t.prior_octet & bmask) == 8'd0);
			end
			dpcc_pkg::TAG_OCTSTR: ok = 1'b1;
			dpcc_pkg::TAG_NULL: ok = (t.byte_count == 5'd0);
			dpcc_pkg::TAG_OID, dpcc_pkg::TAG_RELOID:
				ok = (t.byte_count != 5'd0) && !t.oid_continuing;
			dpcc_pkg::TAG_REAL: begin
				if (t.byte_count == 5'd0) ok = 1'b1;
				else if (t.real_exponent_len == 2'd0) ok = (t.byte_count == 5'd1);
				else ok = (t.byte_count >= {3'd0, t.real_exponent_len} + 5'd2) &&
					t.prior_octet[0];
			end
			dpcc_pkg::TAG_UTF8: ok = (t.utf8_pending == 2'd0);
			dpcc_pkg::TAG_NUMERIC, dpcc_pkg::TAG_PRINTABLE, dpcc_pkg::TAG_IA5,
			dpcc_pkg::TAG_VISIBLE: ok = 1'b1;
			dpcc_pkg::TAG_UTCTIME: ok = (t.byte_count == 5'd13);
			dpcc_pkg::TAG_GENTIME: ok = (t.fraction_phase == dpcc_pkg::FR_ZULU);
			dpcc_pkg::TAG_UNIVERSAL, dpcc_pkg::TAG_BMP: ok = (t.group_phase == 2'd0);
			default: verdict = dpcc_pkg::ST_UNSUPPORTED;
		endcase
		if (verdict != dpcc_pkg::ST_UNSUPPORTED)
			verdict = (ok && !t.invalid_seen) ? dpcc_pkg::ST_OK : dpcc_pkg::ST_INVALID;

		nxt = t;
		if (done) begin
			nxt = '0;
			nxt.elem_tag = t.elem_tag;
		end
	end

endmodule

// File: hdl/der_primitive_content_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER primitive content checker
// Validates canonical DER content of primitive universal elements, one octet
// per beat, and reports a status beat at the end of each element.
// ----------------------------------------------------------------------------
// Output: the status beat is registered and appears in the cycle after the element's last beat is accepted.
// Throughput: one beat per cycle unless a status beat waits on a stalled consumer;
// the state update for a beat is one combinational pass between the element state register and the result register.
// Reset: arst_n clears the element state and the result valid flag.
module der_primitive_content_checker_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] tag_number,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       empty_element,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status
);

	dpcc_pkg::elem_state_t state_q;
	dpcc_pkg::elem_state_t state_nxt;
	dpcc_pkg::item_t       item;
	logic                  done;
	logic [1:0]            verdict;
	logic                  accept;

	assign item = '{tag_number: tag_number, data_byte: data_byte,
		last_byte: last_byte, empty_element: empty_element};

	dpcc_step u_step (
		.cur     (state_q),
		.item    (item),
		.nxt     (state_nxt),
		.done    (done),
		.verdict (verdict)
	);

	// A beat is taken unless a result is waiting and the consumer stalls.
	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (accept) state_q <= state_nxt;
			if (accept) out_valid <= done;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && done) status <= verdict;
	end

`ifndef SYNTHESIS
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3))
		else $error("status code out of range");
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && done) |=> (state_q.byte_count == 5'd0))
		else $error("element state not cleared after last beat");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)))
		else $error("stalled result changed");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DER content checker testbench
// Streams content octets of primitive elements into the checker, predicts the
// status of each element in a local model and compares every status beat.
// ----------------------------------------------------------------------------
module testbench;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] tag_number = 8'd0;
	logic [7:0] data_byte = 8'd0;
	logic       last_byte = 1'b0;
	logic       empty_element = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;

	der_primitive_content_checker_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.tag_number(tag_number), .data_byte(data_byte), .last_byte(last_byte),
		.empty_element(empty_element), .out_valid(out_valid), .out_ready(out_ready),
		.status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	dpcc_pkg::item_t       pending_items[$];
	logic [1:0]            expected_status[$];
	dpcc_pkg::elem_state_t st;
	int          errors = 0;
	int          sent_items = 0;
	int          statuses_seen = 0;
	bit          all_queued = 1'b0;
	bit          calm = 1'b0;
	int          in_gap = 0;
	int          out_gap = 0;

	function automatic bit dig(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic bit printable_char(input logic [7:0] c);
		if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || dig(c))
			return 1'b1;
		return c == 8'h20 || c == 8'h27 || c == 8'h28 || c == 8'h29 || c == 8'h2B ||
			c == 8'h2C || c == 8'h2D || c == 8'h2E || c == 8'h2F || c == 8'h3A ||
			c == 8'h3D || c == 8'h3F;
	endfunction

	function automatic void clear_elem();
		logic [7:0] t;
		t = st.elem_tag;
		st = '0;
		st.elem_tag = t;
	endfunction

	// Digits of a time value; year_pairs leading pairs carry no range check.
	function automatic void time_digit(input int n, input logic [7:0] b, input int year_pairs);
		int f;
		int v;
		int lo[5] = '{1, 1, 0, 0, 0};
		int hi[5] = '{12, 31, 23, 59, 59};
		if (!dig(b)) begin
			st.invalid_seen = 1'b1;
			return;
		end
		if (n % 2 == 0) begin
			st.tens_digit = b[3:0];
			return;
		end
		if (n / 2 < year_pairs) return;
		f = n / 2 - year_pairs;
		if (f > 4) return;
		v = int'(st.tens_digit) * 10 + int'(b[3:0]);
		if (v < lo[f] || v > hi[f]) st.invalid_seen = 1'b1;
	endfunction

	function automatic void real_octet(input int n, input logic [7:0] b);
		int e;
		int m;
		e = int'(st.real_exponent_len);
		if (n == 0) begin
			st.first_octet = b;
			if (!b[7]) begin
				if (!b[6] || b > 8'h43) st.invalid_seen = 1'b1;
			end else if (b[5:4] != 2'd0 || b[3:2] != 2'd0 || b[1:0] == 2'd3) begin
				st.invalid_seen = 1'b1;
			end else begin
				st.real_exponent_len = b[1:0] + 2'd1;
			end
			return;
		end
		if (e == 0) begin
			st.invalid_seen = 1'b1;
			return;
		end
		if (n == 2 && e >= 2)
			if ((st.prior_octet == 8'h00 && !b[7]) || (st.prior_octet == 8'hFF && b[7]))
				st.invalid_seen = 1'b1;
		m = 1 + e;
		if (n == m) st.mantissa_lead_zero = (b == 8'h00);
		if (n == m + 1 && st.mantissa_lead_zero) st.invalid_seen = 1'b1;
	endfunction

	function automatic void utf8_octet(input logic [7:0] b);
		logic [31:0] minv;
		if (st.utf8_pending == 2'd0) begin
			if (!b[7]) return;
			if (b[7:5] == 3'b110) begin
				st.utf8_pending = 2'd1; st.code_point = {27'd0, b[4:0]};
				st.utf8_min_class = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				st.utf8_pending = 2'd2; st.code_point = {28'd0, b[3:0]};
				st.utf8_min_class = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				st.utf8_pending = 2'd3; st.code_point = {29'd0, b[2:0]};
				st.utf8_min_class = 2'd3;
			end else begin
				st.invalid_seen = 1'b1;
			end
			return;
		end
		if (b[7:6] != 2'b10) begin
			st.invalid_seen = 1'b1;
			st.utf8_pending = 2'd0;
			return;
		end
		st.code_point = ((st.code_point << 6) | {26'd0, b[5:0]}) & 32'h1FFFFF;
		st.utf8_pending = st.utf8_pending - 2'd1;
		if (st.utf8_pending == 2'd0) begin
			minv = st.utf8_min_class == 2'd1 ? 32'h80 :
				st.utf8_min_class == 2'd2 ? 32'h800 : 32'h10000;
			if (st.code_point < minv || st.code_point > 32'h10FFFF ||
					(st.code_point >= 32'hD800 && st.code_point <= 32'hDFFF))
				st.invalid_seen = 1'b1;
		end
	endfunction

	function automatic void gentime_tail(input logic [7:0] b);
		case (st.fraction_phase)
			dpcc_pkg::FR_NONE: begin
				if (b == 8'h2E) st.fraction_phase = dpcc_pkg::FR_DOT;
				else if (b == 8'h5A) st.fraction_phase = dpcc_pkg::FR_ZULU;
				else st.invalid_seen = 1'b1;
			end
			dpcc_pkg::FR_DOT, dpcc_pkg::FR_NZ, dpcc_pkg::FR_ZERO: begin
				if (dig(b))
					st.fraction_phase = (b == 8'h30) ? dpcc_pkg::FR_ZERO : dpcc_pkg::FR_NZ;
				else if (b == 8'h5A && st.fraction_phase == dpcc_pkg::FR_NZ)
					st.fraction_phase = dpcc_pkg::FR_ZULU;
				else st.invalid_seen = 1'b1;
			end
			default: st.invalid_seen = 1'b1;
		endcase
	endfunction

	function automatic void absorb_octet(input logic [7:0] b);
		int n;
		n = int'(st.byte_count);
		case (st.elem_tag)
			dpcc_pkg::TAG_BOOLEAN:
				if (n == 0 && b != 8'h00 && b != 8'hFF) st.invalid_seen = 1'b1;
			dpcc_pkg::TAG_INTEGER, dpcc_pkg::TAG_ENUM: begin
				if (n == 0) st.first_octet = b;
				else if (n == 1 && ((st.first_octet == 8'h00 && !b[7]) ||
						(st.first_octet == 8'hFF && b[7])))
					st.invalid_seen = 1'b1;
			end
			dpcc_pkg::TAG_BITSTR: if (n == 0) begin
				st.first_octet = b;
				if (b > 8'd7) st.invalid_seen = 1'b1;
			end
			dpcc_pkg::TAG_OID, dpcc_pkg::TAG_RELOID: begin
				if (!st.oid_continuing && b == 8'h80) st.invalid_seen = 1'b1;
				st.oid_continuing = b[7];
			end
			dpcc_pkg::TAG_REAL: real_octet(n, b);
			dpcc_pkg::TAG_UTF8: utf8_octet(b);
			dpcc_pkg::TAG_NUMERIC: if (!dig(b) && b != 8'h20) st.invalid_seen = 1'b1;
			dpcc_pkg::TAG_PRINTABLE: if (!printable_char(b)) st.invalid_seen = 1'b1;
			dpcc_pkg::TAG_IA5: if (b > 8'h7F) st.invalid_seen = 1'b1;
			dpcc_pkg::TAG_VISIBLE: if (b < 8'h20 || b > 8'h7E) st.invalid_seen = 1'b1;
			dpcc_pkg::TAG_UTCTIME: begin
				if (n < 12) time_digit(n, b, 1);
				else if (n > 12 || b != 8'h5A) st.invalid_seen = 1'b1;
			end
			dpcc_pkg::TAG_GENTIME: begin
				if (n < 14) time_digit(n, b, 2);
				else gentime_tail(b);
			end
			dpcc_pkg::TAG_UNIVERSAL: begin
				st.code_point = (st.code_point << 8) | {24'd0, b};
				st.group_phase = st.group_phase + 2'd1;
				if (st.group_phase == 2'd0 && (st.code_point > 32'h10FFFF ||
						(st.code_point >= 32'hD800 && st.code_point <= 32'hDFFF)))
					st.invalid_seen = 1'b1;
			end
			dpcc_pkg::TAG_BMP: begin
				st.code_point = ((st.code_point << 8) | {24'd0, b}) & 32'hFFFF;
				st.group_phase = {1'b0, ~st.group_phase[0]};
				if (st.group_phase == 2'd0 && st.code_point >= 32'hD800 &&
						st.code_point <= 32'hDFFF)
					st.invalid_seen = 1'b1;
			end
			default: ;
		endcase
		st.prior_octet = b;
		if (st.byte_count != 5'd31) st.byte_count = st.byte_count + 5'd1;
	endfunction

	function automatic logic [1:0] element_verdict();
		int len;
		bit good;
		len = int'(st.byte_count);
		case (st.elem_tag)
			dpcc_pkg::TAG_BOOLEAN: good = len == 1;
			dpcc_pkg::TAG_INTEGER, dpcc_pkg::TAG_ENUM: good = len >= 1;
			dpcc_pkg::TAG_BITSTR: begin
				if (len == 0) good = 1'b0;
				else if (len == 1) good = st.first_octet == 8'd0;
				else good = (st.prior_octet & ((8'd1 << st.first_octet[2:0]) - 8'd1)) == 8'd0;
			end
			dpcc_pkg::TAG_OCTSTR: good = 1'b1;
			dpcc_pkg::TAG_NULL: good = len == 0;
			dpcc_pkg::TAG_OID, dpcc_pkg::TAG_RELOID: good = len >= 1 && !st.oid_continuing;
			dpcc_pkg::TAG_REAL: begin
				if (len == 0) good = 1'b1;
				else if (st.real_exponent_len == 2'd0) good = len == 1;
				else good = len >= int'(st.real_exponent_len) + 2 && st.prior_octet[0];
			end
			dpcc_pkg::TAG_UTF8: good = st.utf8_pending == 2'd0;
			dpcc_pkg::TAG_NUMERIC, dpcc_pkg::TAG_PRINTABLE, dpcc_pkg::TAG_IA5,
			dpcc_pkg::TAG_VISIBLE: good = 1'b1;
			dpcc_pkg::TAG_UTCTIME: good = len == 13;
			dpcc_pkg::TAG_GENTIME: good = st.fraction_phase == dpcc_pkg::FR_ZULU;
			dpcc_pkg::TAG_UNIVERSAL, dpcc_pkg::TAG_BMP: good = st.group_phase == 2'd0;
			default: return dpcc_pkg::ST_UNSUPPORTED;
		endcase
		return (good && !st.invalid_seen) ? dpcc_pkg::ST_OK : dpcc_pkg::ST_INVALID;
	endfunction

	// Advances the local model by one accepted beat.
	function automatic void predict_status(input dpcc_pkg::item_t it);
		if (st.byte_count == 5'd0) begin
			clear_elem();
			st.elem_tag = it.tag_number;
		end
		if (!it.empty_element) absorb_octet(it.data_byte);
		if (it.empty_element || it.last_byte) begin
			expected_status.push_back(element_verdict());
			clear_elem();
		end
	endfunction

	// Pushes an element; any content beat may carry a random tag, only the first one counts.
	task automatic push_element(input logic [7:0] tag, input logic [7:0] octets[$]);
		dpcc_pkg::item_t it;
		if (octets.size() == 0) begin
			it = '{tag_number: tag, data_byte: 8'($urandom), last_byte: 1'($urandom),
				empty_element: 1'b1};
			pending_items.push_back(it);
			return;
		end
		foreach (octets[i]) begin
			it.tag_number = ($urandom_range(0, 3) == 0) ? 8'($urandom) : tag;
			it.data_byte = octets[i];
			it.last_byte = (i == octets.size() - 1);
			it.empty_element = 1'b0;
			pending_items.push_back(it);
		end
	endtask

	function automatic logic [7:0] pick_tag();
		logic [7:0] tags[18] = '{dpcc_pkg::TAG_BOOLEAN, dpcc_pkg::TAG_INTEGER,
			dpcc_pkg::TAG_BITSTR, dpcc_pkg::TAG_OCTSTR, dpcc_pkg::TAG_NULL,
			dpcc_pkg::TAG_OID, dpcc_pkg::TAG_REAL, dpcc_pkg::TAG_ENUM, dpcc_pkg::TAG_UTF8,
			dpcc_pkg::TAG_RELOID, dpcc_pkg::TAG_NUMERIC, dpcc_pkg::TAG_PRINTABLE,
			dpcc_pkg::TAG_IA5, dpcc_pkg::TAG_UTCTIME, dpcc_pkg::TAG_GENTIME,
			dpcc_pkg::TAG_VISIBLE, dpcc_pkg::TAG_UNIVERSAL, dpcc_pkg::TAG_BMP};
		if ($urandom_range(0, 15) == 0) return 8'($urandom);
		return tags[$urandom_range(0, 17)];
	endfunction

	function automatic logic [7:0] ascii_digit();
		return 8'(8'h30 + $urandom_range(0, 9));
	endfunction

	// Mostly well-formed content for the tag, with occasional corruption.
	task automatic random_element();
		logic [7:0] tag;
		logic [7:0] o[$];
		int len;
		int e;
		logic [31:0] cp;
		tag = pick_tag();
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 8);
		case (tag)
			dpcc_pkg::TAG_BOOLEAN: o.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
			dpcc_pkg::TAG_INTEGER, dpcc_pkg::TAG_ENUM: begin
				o.push_back($urandom_range(0, 1) ? 8'($urandom) :
					8'($urandom_range(0, 1) * 255));
				repeat (len) o.push_back(8'($urandom));
			end
			dpcc_pkg::TAG_BITSTR: begin
				o.push_back(8'($urandom_range(0, 7)));
				repeat (len) o.push_back(8'($urandom));
			end
			dpcc_pkg::TAG_OID, dpcc_pkg::TAG_RELOID: repeat (len + 1) begin
				if ($urandom_range(0, 2) == 0) o.push_back(8'(8'h80 | $urandom_range(0, 127)));
				else o.push_back(8'($urandom_range(0, 127)));
			end
			dpcc_pkg::TAG_REAL: begin
				if ($urandom_range(0, 2) == 0) begin
					o.push_back(8'(8'h40 + $urandom_range(0, 3)));
				end else begin
					e = $urandom_range(0, 2);
					o.push_back(8'(8'h80 | ($urandom_range(0, 1) << 6) | e));
					repeat (e + 1) o.push_back(8'($urandom));
					repeat ($urandom_range(0, 4)) o.push_back(8'($urandom));
					o.push_back(8'($urandom) | 8'h01);
				end
			end
			dpcc_pkg::TAG_UTF8: repeat (len) begin
				cp = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32'h10FFFF) :
					$urandom_range(0, 32'h7FF);
				if (cp < 32'h80) o.push_back(cp[7:0]);
				else if (cp < 32'h800) begin
					o.push_back(8'(8'hC0 | (cp >> 6))); o.push_back(8'(8'h80 | (cp & 8'h3F)));
				end else if (cp < 32'h10000) begin
					o.push_back(8'(8'hE0 | (cp >> 12)));
					o.push_back(8'(8'h80 | ((cp >> 6) & 8'h3F)));
					o.push_back(8'(8'h80 | (cp & 8'h3F)));
				end else begin
					o.push_back(8'(8'hF0 | (cp >> 18)));
					o.push_back(8'(8'h80 | ((cp >> 12) & 8'h3F)));
					o.push_back(8'(8'h80 | ((cp >> 6) & 8'h3F)));
					o.push_back(8'(8'h80 | (cp & 8'h3F)));
				end
			end
			dpcc_pkg::TAG_NUMERIC:
				repeat (len) o.push_back($urandom_range(0, 5) == 0 ? 8'h20 : ascii_digit());
			dpcc_pkg::TAG_PRINTABLE, dpcc_pkg::TAG_VISIBLE:
				repeat (len) o.push_back(8'($urandom_range(8'h20, 8'h7E)));
			dpcc_pkg::TAG_IA5: repeat (len) o.push_back(8'($urandom_range(0, 8'h7F)));
			dpcc_pkg::TAG_UTCTIME, dpcc_pkg::TAG_GENTIME: begin
				repeat (tag == dpcc_pkg::TAG_GENTIME ? 2 : 1) begin
					o.push_back(ascii_digit()); o.push_back(ascii_digit());
				end
				begin
					int hi_f[5] = '{12, 28, 23, 59, 59};
					int lo_f[5] = '{1, 1, 0, 0, 0};
					for (int f = 0; f < 5; f++) begin
						e = $urandom_range(lo_f[f], hi_f[f]);
						o.push_back(8'(8'h30 + e / 10)); o.push_back(8'(8'h30 + e % 10));
					end
				end
				if (tag == dpcc_pkg::TAG_GENTIME && $urandom_range(0, 1)) begin
					o.push_back(8'h2E);
					repeat ($urandom_range(0, 3)) o.push_back(ascii_digit());
					o.push_back(8'(8'h31 + $urandom_range(0, 8)));
				end
				o.push_back(8'h5A);
			end
			dpcc_pkg::TAG_UNIVERSAL: repeat (len % 4 + 1) begin
				cp = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 32'h10FFFF);
				o.push_back(cp[31:24]); o.push_back(cp[23:16]);
				o.push_back(cp[15:8]); o.push_back(cp[7:0]);
			end
			dpcc_pkg::TAG_BMP: repeat (len) begin
				cp = $urandom;
				o.push_back(cp[15:8]); o.push_back(cp[7:0]);
			end
			default: repeat (len) o.push_back(8'($urandom));
		endcase
		// Noise: drop, flip or add an octet now and then.
		case ($urandom_range(0, 9))
			0: if (o.size() > 0) o.delete($urandom_range(0, o.size() - 1));
			1: if (o.size() > 0) o[$urandom_range(0, o.size() - 1)] = 8'($urandom);
			2: o.push_back(8'($urandom));
			default: ;
		endcase
		push_element(tag, o);
	endtask

	initial begin
		logic [7:0] q[$];
		dpcc_pkg::item_t it;
		push_element(dpcc_pkg::TAG_BOOLEAN, '{8'hFF});
		push_element(dpcc_pkg::TAG_BOOLEAN, '{8'h01});
		push_element(dpcc_pkg::TAG_INTEGER, '{8'h00, 8'h7F});
		push_element(dpcc_pkg::TAG_ENUM, '{8'hFF, 8'h80});
		push_element(dpcc_pkg::TAG_INTEGER, '{});
		push_element(dpcc_pkg::TAG_BITSTR, '{8'h03, 8'hF8});
		push_element(dpcc_pkg::TAG_NULL, '{});
		push_element(dpcc_pkg::TAG_OID, '{8'h2A, 8'h80, 8'h01});
		push_element(dpcc_pkg::TAG_REAL, '{8'h80, 8'h00, 8'h01});
		push_element(dpcc_pkg::TAG_REAL, '{8'h43});
		push_element(dpcc_pkg::TAG_REAL, '{});
		push_element(dpcc_pkg::TAG_UTF8, '{8'hED, 8'hA0, 8'h80});
		push_element(dpcc_pkg::TAG_UTF8, '{8'hC0, 8'h80});
		push_element(dpcc_pkg::TAG_UTCTIME, '{8'h39, 8'h39, 8'h31, 8'h32, 8'h33, 8'h31,
			8'h32, 8'h33, 8'h35, 8'h39, 8'h35, 8'h39, 8'h5A});
		push_element(dpcc_pkg::TAG_GENTIME, '{8'h32, 8'h30, 8'h32, 8'h30, 8'h30, 8'h31,
			8'h33, 8'h31, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h2E, 8'h35, 8'h5A});
		push_element(dpcc_pkg::TAG_UNIVERSAL, '{8'h00, 8'h11, 8'h00, 8'h00});
		push_element(dpcc_pkg::TAG_BMP, '{8'hD8, 8'h00});
		push_element(8'hFF, '{8'h00});
		// An empty beat closing an element that already has octets.
		push_element(dpcc_pkg::TAG_BITSTR, '{8'h00});
		pending_items[$].last_byte = 1'b0;
		it = '{tag_number: dpcc_pkg::TAG_NULL, data_byte: 8'hFF, last_byte: 1'b0,
			empty_element: 1'b1};
		pending_items.push_back(it);
		// Long content past the counter's saturation point.
		q = {};
		repeat (36) q.push_back(8'h41);
		push_element(dpcc_pkg::TAG_OCTSTR, q);
		while (pending_items.size() < 1850) random_element();
		all_queued = 1'b1;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Beat driver and output ready driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sent_items <= sent_items + 1;
			if (!(in_valid && !in_ready)) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 11) == 0) begin
					in_gap <= $urandom_range(1, 9) - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					{tag_number, data_byte, last_byte, empty_element} <= pending_items[0];
					predict_status(pending_items.pop_front());
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_gap <= $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			if (pending_items.size() < 200) calm <= 1'b1;
		end
	end

	// Status monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			statuses_seen <= statuses_seen + 1;
			if (expected_status.size() == 0) begin
				$display("%0t: status expected none actual %0d", $time, status);
				errors <= errors + 1;
			end else begin
				if (status !== expected_status[0]) begin
					$display("%0t: status expected %0d actual %0d", $time,
						expected_status[0], status);
					errors <= errors + 1;
				end
				void'(expected_status.pop_front());
			end
		end
	end

	initial begin
		wait (all_queued && pending_items.size() == 0);
		@(posedge clk);
		while (in_valid || expected_status.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Covered %0d content beats and %0d element status checks.",
			sent_items, statuses_seen);
		if (errors == 0 && expected_status.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
